@@ rtl/core/vlmr_pkg.sv @@
// Shared types, constants and helpers of the variable-length message ring.
`default_nettype none
package vlmr_pkg;

    // Ring geometry and message limits
    localparam int RING_WORDS        = 256;
    localparam int ADDR_W            = $clog2(RING_WORDS);
    localparam int MAX_PAYLOAD_BYTES = 256;
    localparam int CNT_W             = $clog2(MAX_PAYLOAD_BYTES / 4 + 1);

    // Fixed field widths
    localparam int IDX_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int WORD_W  = 32;
    localparam int MAGIC_W = 16;
    localparam int LOG2_W  = 4;
    localparam int ESIZE_W = 11;
    localparam int ASZ_W   = 17;   // rounded size of a 16-bit byte count
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;

    localparam logic [LOG2_W-1:0] CAP_LOG2_RESET = LOG2_W'(8);
    localparam logic [LOG2_W-1:0] CAP_LOG2_MIN   = LOG2_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY_LOG2 = 2'd0,
        CFG_MAGIC_WORD    = 2'd1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ_BEGIN  = 3'd0,
        OP_ENQ_WORD   = 3'd1,
        OP_DEQUEUE    = 3'd2,
        OP_CONS_RESET = 3'd3,
        OP_INIT       = 3'd4,
        OP_SHUTDOWN   = 3'd5,
        OP_QUERY      = 3'd6
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_FULL      = 3'd2,
        ST_INVALID   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_BAD_MAGIC = 3'd5,
        ST_TOO_SMALL = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MODE_INVALID = 2'd0,
        MODE_RESET   = 2'd1,
        MODE_OPER    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HDR1,
        S_DQ_CHECK,
        S_DQ_LOAD,
        S_DQ_SEND
    } ctrl_state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_BEGIN,
        ACT_HDR1,
        ACT_WORD,
        ACT_DQ_EMPTY,
        ACT_DQ_HEAD,
        ACT_DQ_LOAD,
        ACT_CONS_RESET,
        ACT_INIT,
        ACT_SHUTDOWN,
        ACT_QUERY
    } act_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_FIRST,
        RD_PTR
    } rd_sel_t;

    typedef struct packed {
        logic    in_load;
        act_t    act;
        rd_sel_t rd_sel;
    } vlmr_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            begin_ok;
        logic            dq_empty;
        logic            dq_stream;
        logic            more;
        logic            out_free;
    } vlmr_sts_t;

    // Slot mask for the ring size in use: 2^max(lg,2) words, capped at the store.
    function automatic logic [ADDR_W-1:0] cap_mask(input logic [LOG2_W-1:0] lg);
        logic [LOG2_W-1:0] lg_eff;
        logic [ADDR_W-1:0] m;
        lg_eff = (lg < CAP_LOG2_MIN) ? CAP_LOG2_MIN : lg;
        for (int i = 0; i < ADDR_W; i++) begin
            m[i] = (i < int'(lg_eff));
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/vlmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vlmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/vlmr_ctrl.sv @@
// Sequencing state machine of the message ring.
`default_nettype none
module vlmr_ctrl
    import vlmr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire vlmr_sts_t sts,
    output vlmr_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.in_load = 1'b0;
        cmd.act     = ACT_NONE;
        cmd.rd_sel  = RD_PTR;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.rd_sel = RD_HEAD;   // header read, used by dequeue only
                if (sts.out_free) begin
                    state_next = S_IDLE;
                    unique case (sts.opcode)
                        OP_ENQ_BEGIN: begin
                            cmd.act = ACT_BEGIN;
                            if (sts.begin_ok) begin
                                state_next = S_HDR1;
                            end
                        end
                        OP_ENQ_WORD:   cmd.act = ACT_WORD;
                        OP_DEQUEUE: begin
                            if (sts.dq_empty) begin
                                cmd.act = ACT_DQ_EMPTY;
                            end else begin
                                state_next = S_DQ_CHECK;
                            end
                        end
                        OP_CONS_RESET: cmd.act = ACT_CONS_RESET;
                        OP_INIT:       cmd.act = ACT_INIT;
                        OP_SHUTDOWN:   cmd.act = ACT_SHUTDOWN;
                        default:       cmd.act = ACT_QUERY;
                    endcase
                end
            end
            S_HDR1: begin
                cmd.act    = ACT_HDR1;
                state_next = S_IDLE;
            end
            S_DQ_CHECK: begin
                cmd.act    = ACT_DQ_HEAD;
                cmd.rd_sel = RD_FIRST;
                state_next = sts.dq_stream ? S_DQ_LOAD : S_IDLE;
            end
            S_DQ_LOAD: begin
                cmd.act    = ACT_DQ_LOAD;
                state_next = S_DQ_SEND;
            end
            S_DQ_SEND: begin
                if (sts.out_free) begin
                    state_next = sts.more ? S_DQ_LOAD : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/vlmr_dp.sv @@
// Datapath of the message ring: indices, ring store, checks and result register.
`default_nettype none
module vlmr_dp
    import vlmr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire vlmr_cmd_t             cmd,
    output vlmr_sts_t                  sts,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [STAT_W-1:0]          m_tuser,
    output logic                       m_tlast
);

    localparam logic [ASZ_W-1:0]  MAX_ASZ   = ASZ_W'(MAX_PAYLOAD_BYTES);
    localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(MAX_PAYLOAD_BYTES);
    localparam logic [ASZ_W-1:0]  ROUND_ADD = ASZ_W'(3);
    localparam logic [ASZ_W-1:0]  ROUND_MSK = ~ASZ_W'(3);
    localparam logic [ASZ_W-1:0]  HDR_WORDS = ASZ_W'(2);

    // Captured input item
    logic [OP_W-1:0]   in_op_reg;
    logic [SIZE_W-1:0] in_size_reg;
    logic [WORD_W-1:0] in_data_reg;

    // Queue state
    logic [IDX_W-1:0]   swi_reg, swi_next;
    logic [IDX_W-1:0]   sri_reg, sri_next;
    logic [IDX_W-1:0]   ewi_reg, ewi_next;
    logic [IDX_W-1:0]   eri_reg, eri_next;
    logic [IDX_W-1:0]   pend_reg, pend_next;
    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   wrem_reg, wrem_next;
    logic [LOG2_W-1:0]  cap_lg_reg;
    logic [MAGIC_W-1:0] magic_reg;

    // Dequeue streaming
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ESIZE_W-1:0] esize_reg, esize_next;

    // Result register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_last_reg;
    logic [ESIZE_W-1:0] out_esize_reg;
    logic [IDX_W-1:0]   out_count_reg;
    logic               out_empty_reg;

    logic               emit;
    status_t            e_status;
    logic [WORD_W-1:0]  e_word;
    logic               e_last;
    logic [ESIZE_W-1:0] e_esize;

    // Ring store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    vlmr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_WORDS)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Ring geometry and occupancy
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W:0]   cap;
    logic [IDX_W-1:0]  cap16;
    logic [IDX_W-1:0]  used;
    logic [ASZ_W-1:0]  free_w;

    assign mask   = cap_mask(cap_lg_reg);
    assign cap    = {1'b0, mask} + (ADDR_W + 1)'(1);
    assign cap16  = IDX_W'(cap);
    assign used   = swi_reg - sri_reg;
    assign free_w = (used >= cap16) ? '0 : {1'b0, cap16 - used};

    function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] idx,
                                               input logic [ADDR_W-1:0] m);
        return idx[ADDR_W-1:0] & m;
    endfunction

    // Enqueue-begin checks
    logic [ASZ_W-1:0] beg_asize;
    logic [ASZ_W-1:0] beg_need;
    logic             beg_too_large;
    logic             beg_mode_ok;
    status_t          beg_status;

    assign beg_asize     = ({1'b0, in_size_reg} + ROUND_ADD) & ROUND_MSK;
    assign beg_need      = HDR_WORDS + (beg_asize >> 2);
    assign beg_too_large = in_size_reg > MAX_SIZE;
    assign beg_mode_ok   = (mode_reg == MODE_OPER) || (mode_reg == MODE_RESET);

    always_comb begin
        priority if (beg_too_large) begin
            beg_status = ST_TOO_LARGE;
        end else if (!beg_mode_ok) begin
            beg_status = ST_INVALID;
        end else if (beg_need > free_w) begin
            beg_status = ST_FULL;
        end else begin
            beg_status = ST_OK;
        end
    end

    // Dequeue header checks, header word on the RAM read port
    logic [ASZ_W-1:0] hd_asize;
    logic [ASZ_W-1:0] hd_nw;
    logic             hd_bad;
    status_t          dq_status;

    assign hd_asize = ({1'b0, ram_rdata[WORD_W-1:MAGIC_W]} + ROUND_ADD) & ROUND_MSK;
    assign hd_nw    = hd_asize >> 2;
    assign hd_bad   = (ram_rdata[MAGIC_W-1:0] != magic_reg) || (hd_asize > MAX_ASZ)
                      || ((HDR_WORDS + hd_nw) > {1'b0, used});

    always_comb begin
        priority if (hd_bad) begin
            dq_status = ST_BAD_MAGIC;
        end else if (hd_asize > {1'b0, in_size_reg}) begin
            dq_status = ST_TOO_SMALL;
        end else begin
            dq_status = ST_OK;
        end
    end

    // Status to the controller
    assign sts.opcode    = in_op_reg;
    assign sts.begin_ok  = (beg_status == ST_OK);
    assign sts.dq_empty  = (mode_reg != MODE_OPER) || (used == '0);
    assign sts.dq_stream = (dq_status == ST_OK) && (hd_nw != '0);
    assign sts.more      = (cnt_reg != '0);
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Read address
    always_comb begin
        unique case (cmd.rd_sel)
            RD_HEAD:  ram_raddr = slot(sri_reg, mask);
            RD_FIRST: ram_raddr = slot(sri_reg + IDX_W'(2), mask);
            default:  ram_raddr = slot(rd_ptr_reg, mask);
        endcase
    end

    // Next state per action
    always_comb begin
        swi_next    = swi_reg;
        sri_next    = sri_reg;
        ewi_next    = ewi_reg;
        eri_next    = eri_reg;
        pend_next   = pend_reg;
        mode_next   = mode_reg;
        wrem_next   = wrem_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        esize_next  = esize_reg;
        ram_we      = 1'b0;
        ram_waddr   = slot(swi_reg, mask);
        ram_wdata   = '0;
        emit        = 1'b0;
        e_status    = ST_OK;
        e_word      = '0;
        e_last      = 1'b1;
        e_esize     = '0;
        unique case (cmd.act)
            ACT_BEGIN: begin
                wrem_next = '0;   // any open message is dropped
                if (!beg_too_large && (mode_reg == MODE_RESET)) begin
                    mode_next = MODE_OPER;
                end
                if (beg_status == ST_OK) begin
                    ram_we    = 1'b1;
                    ram_wdata = {beg_asize[IDX_W-1:0], magic_reg};
                end else begin
                    emit     = 1'b1;
                    e_status = beg_status;
                end
            end
            ACT_HDR1: begin
                ram_we    = 1'b1;
                ram_waddr = slot(swi_reg + IDX_W'(1), mask);
                pend_next = swi_reg + IDX_W'(2);
                wrem_next = CNT_W'(beg_asize >> 2);
                if ((beg_asize >> 2) == '0) begin
                    // empty message commits at once
                    if (mode_reg == MODE_OPER) begin
                        swi_next = swi_reg + IDX_W'(2);
                        ewi_next = ewi_reg + IDX_W'(1);
                    end
                end
                emit = 1'b1;
            end
            ACT_WORD: begin
                if (wrem_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(pend_reg, mask);
                    ram_wdata = in_data_reg;
                    pend_next = pend_reg + IDX_W'(1);
                    wrem_next = wrem_reg - CNT_W'(1);
                    if ((wrem_reg == CNT_W'(1)) && (mode_reg == MODE_OPER)) begin
                        swi_next = pend_reg + IDX_W'(1);
                        ewi_next = ewi_reg + IDX_W'(1);
                    end
                end
                emit = 1'b1;
            end
            ACT_DQ_EMPTY: begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
            end
            ACT_DQ_HEAD: begin
                if (dq_status != ST_OK) begin
                    emit     = 1'b1;
                    e_status = dq_status;
                end else begin
                    sri_next    = sri_reg + IDX_W'(2) + IDX_W'(hd_nw);
                    eri_next    = eri_reg + IDX_W'(1);
                    rd_ptr_next = sri_reg + IDX_W'(2);
                    cnt_next    = CNT_W'(hd_nw);
                    esize_next  = ESIZE_W'(hd_asize);
                    emit        = (hd_nw == '0);
                end
            end
            ACT_DQ_LOAD: begin
                emit        = 1'b1;
                e_word      = ram_rdata;
                e_last      = (cnt_reg == CNT_W'(1));
                e_esize     = esize_reg;
                rd_ptr_next = rd_ptr_reg + IDX_W'(1);
                cnt_next    = cnt_reg - CNT_W'(1);
            end
            ACT_CONS_RESET: begin
                wrem_next = '0;
                mode_next = MODE_RESET;
                emit      = 1'b1;
            end
            ACT_INIT: begin
                wrem_next = '0;
                swi_next  = '0;
                sri_next  = '0;
                ewi_next  = '0;
                eri_next  = '0;
                mode_next = MODE_OPER;
                emit      = 1'b1;
            end
            ACT_SHUTDOWN: begin
                wrem_next = '0;
                mode_next = MODE_INVALID;
                emit      = 1'b1;
            end
            ACT_QUERY: emit = 1'b1;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swi_reg       <= '0;
            sri_reg       <= '0;
            ewi_reg       <= '0;
            eri_reg       <= '0;
            pend_reg      <= '0;
            mode_reg      <= MODE_INVALID;
            wrem_reg      <= '0;
            cap_lg_reg    <= CAP_LOG2_RESET;
            magic_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            swi_reg  <= swi_next;
            sri_reg  <= sri_next;
            ewi_reg  <= ewi_next;
            eri_reg  <= eri_next;
            pend_reg <= pend_next;
            mode_reg <= mode_next;
            wrem_reg <= wrem_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_CAPACITY_LOG2: cap_lg_reg <= cfg_data[LOG2_W-1:0];
                    CFG_MAGIC_WORD:    magic_reg  <= cfg_data[MAGIC_W-1:0];
                    default: ;
                endcase
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        cnt_reg    <= cnt_next;
        esize_reg  <= esize_next;
        if (cmd.in_load) begin
            in_op_reg   <= s_tuser;
            in_size_reg <= s_tdata[SIZE_W-1:0];
            in_data_reg <= s_tdata[SIZE_W+WORD_W-1:SIZE_W];
        end
        if (emit) begin
            out_status_reg <= e_status;
            out_word_reg   <= e_word;
            out_last_reg   <= e_last;
            out_esize_reg  <= e_esize;
            out_count_reg  <= ewi_next - eri_next;
            out_empty_reg  <= (mode_next != MODE_OPER) || ((swi_next - sri_next) == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - ESIZE_W - IDX_W - 1){1'b0}},
                       out_empty_reg, out_count_reg, out_esize_reg, out_word_reg};

endmodule
`default_nettype wire

@@ rtl/core/variable_length_message_ring_unit.sv @@
// Top level of the variable-length message ring unit.
`default_nettype none
// A ring of 32-bit words in a single RAM holds variable-length messages, each
// a two-word header (magic in 15:0, payload bytes rounded to four in 31:16;
// second word zero) and its payload. One operation is taken per input transfer,
// selected by s_tuser: enqueue-begin, enqueue-word, dequeue, consumer reset,
// init, shutdown, query. Every operation answers with one result transfer,
// except a successful dequeue of a non-empty message, which answers with one
// transfer per payload word, tlast on the final one. Operations are handled
// one at a time: after acceptance most operations run in S_EXEC; an enqueue-begin
// that writes its header also passes S_HDR1 (two header words through one RAM write
// port); a dequeue reads and checks the header in S_EXEC and S_DQ_CHECK, then loads
// each payload word from the registered RAM read port in S_DQ_LOAD and sends it in
// S_DQ_SEND. A new item is accepted while the last result still waits in the output
// register; work starts once that register is free. The ring needs no clearing pass
// after reset. The user must write configuration through cfg_* only while the unit
// is idle, not enforced by the unit; index 0 is capacity_log2, index 1 is magic_word.
module variable_length_message_ring_unit
    import vlmr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input item
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // size_bytes[15:0], data_word[47:16]
    input  wire logic [OP_W-1:0]       s_tuser,   // opcode[2:0]
    // result item
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // payload_word[31:0],
                                                  // entry_size_bytes[42:32],
                                                  // entry_count[58:43],
                                                  // empty_flag[59], zero above
    output logic [STAT_W-1:0]          m_tuser,   // status[2:0]
    output logic                       m_tlast,   // last_word
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    vlmr_cmd_t cmd;
    vlmr_sts_t sts;

    // register writes always complete in one transfer
    assign cfg_ready = 1'b1;

    vlmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vlmr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
